@@ sv/psfp_pkg.sv @@
`default_nettype none

package psfp_pkg;

	// frame layout
	localparam int FRAME_BYTES = 21;
	localparam int POS_W       = $clog2(FRAME_BYTES + 1);

	localparam logic [POS_W-1:0] POS_IDLE   = POS_W'(FRAME_BYTES);
	localparam logic [POS_W-1:0] LAST_BYTE  = POS_W'(FRAME_BYTES - 1);
	localparam logic [POS_W-1:0] BYTE_STAT  = POS_W'(0);
	localparam logic [POS_W-1:0] BYTE_LANE  = POS_W'(1);
	localparam logic [POS_W-1:0] BYTE_X0    = POS_W'(2);
	localparam logic [POS_W-1:0] BYTE_X1    = POS_W'(3);
	localparam logic [POS_W-1:0] BYTE_X2    = POS_W'(4);
	localparam logic [POS_W-1:0] BYTE_X3    = POS_W'(5);
	localparam logic [POS_W-1:0] BYTE_Y0    = POS_W'(6);
	localparam logic [POS_W-1:0] BYTE_Y1    = POS_W'(7);
	localparam logic [POS_W-1:0] BYTE_ANG0  = POS_W'(10);
	localparam logic [POS_W-1:0] BYTE_ANG1  = POS_W'(11);
	localparam logic [POS_W-1:0] BYTE_TAG0  = POS_W'(14);
	localparam logic [POS_W-1:0] BYTE_TAG1  = POS_W'(15);
	localparam logic [POS_W-1:0] BYTE_TAG2  = POS_W'(16);
	localparam logic [POS_W-1:0] BYTE_TAG3  = POS_W'(17);

	// decoding limits, tenths
	localparam logic [23:0]        X_SIGN_LIMIT = 24'd2000;
	localparam logic [13:0]        Y_SIGN_LIMIT = 14'd2000;
	localparam logic signed [16:0] ANG_LOW      = -17'sd1800;
	localparam logic signed [16:0] ANG_TURN     = 17'sd3600;
	localparam logic signed [16:0] ANG_SAT_MIN  = -17'sd16384;
	localparam logic signed [16:0] ANG_SAT_MAX  = 17'sd16383;

	// queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// bus widths
	localparam int CFG_DATA_W = 17;
	localparam int OUT_DATA_W = 96;

	// configuration register indexes
	typedef enum logic [1:0] {
		CFG_X_OFFSET     = 2'd0,
		CFG_Y_OFFSET     = 2'd1,
		CFG_ANGLE_OFFSET = 2'd2
	} cfg_index_t;

	// calibration offsets seen by the back end
	typedef struct packed {
		logic [16:0] x_offset;
		logic [13:0] y_offset;
		logic [12:0] angle_offset;
	} cal_t;

	// raw fields of one complete frame
	typedef struct packed {
		logic [7:0]  status_byte;
		logic [6:0]  lane_bits;
		logic [23:0] x_raw;
		logic [13:0] y_raw;
		logic [13:0] angle_raw;
		logic [27:0] tag_raw;
	} frame_rec_t;

endpackage

`default_nettype wire

@@ sv/position_sensor_frame_parser.sv @@
// Position sensor frame parser. Takes one response byte per beat on the s_ side (s_tuser
// high marks byte 0 of a frame) and, on the last byte of a frame, emits one decoded record on
// the m_ side: flags, tag id and x, y, angle in tenths with the calibration offsets
// subtracted. Bytes are taken one per clock while the record queue has room. On the beat of
// the last byte the two-entry record queue captures the raw record; the decode arithmetic
// then loads the output register from the queue head once that register is free, and the
// m_ beat is offered from it. The queue lets the byte side keep running while a record
// waits on m_tready; s_tready drops only when the output register and both queue entries
// are occupied. Offsets are written over the cfg port, reset to zero and are assumed
// stable while records are in flight.
`default_nettype none

module position_sensor_frame_parser import psfp_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [7:0]            s_tdata,   // rx_byte
	input  wire logic                  s_tuser,   // frame_start
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// head_id, lane_count[2], no_lane, no_position, tag_seen, tag_number[28],
	// x_tenths[26], y_tenths[16], angle_tenths[15], zero fill[5]
	output logic [OUT_DATA_W-1:0]      m_tdata,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [1:0]            cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	cal_t       cal_q;
	frame_rec_t push_rec, pop_rec;
	logic       push, pop, q_full, q_empty;

	// calibration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index_t'(cfg_index))
				CFG_X_OFFSET:     cal_q.x_offset     <= cfg_data[16:0];
				CFG_Y_OFFSET:     cal_q.y_offset     <= cfg_data[13:0];
				CFG_ANGLE_OFFSET: cal_q.angle_offset <= cfg_data[12:0];
				default: begin
				end
			endcase
		end
	end

	psfp_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_valid  (s_tvalid),
		.byte_ready  (s_tready),
		.rx_byte     (s_tdata),
		.frame_start (s_tuser),
		.queue_full  (q_full),
		.rec_push    (push),
		.rec_data    (push_rec)
	);

	psfp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_rec),
		.full      (q_full),
		.pop       (pop),
		.empty     (q_empty),
		.pop_data  (pop_rec)
	);

	psfp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.rec_avail (!q_empty),
		.rec       (pop_rec),
		.rec_pop   (pop),
		.cal       (cal_q),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata)
	);

endmodule

`default_nettype wire

@@ sv/psfp_front.sv @@
`default_nettype none

module psfp_front import psfp_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       byte_valid,
	output logic            byte_ready,
	input  wire logic [7:0] rx_byte,
	input  wire logic       frame_start,
	input  wire logic       queue_full,
	output logic            rec_push,
	output frame_rec_t      rec_data
);

	logic [POS_W-1:0] pos_q, pos_d;
	frame_rec_t       rec_q, rec_d;
	logic             take;
	logic [6:0]       grp;

	assign byte_ready = !queue_full;
	assign take       = byte_valid && byte_ready;
	assign grp        = rx_byte[6:0];

	// byte counter and field capture
	always_comb begin
		pos_d = pos_q;
		rec_d = rec_q;
		if (take) begin
			if (frame_start) begin
				pos_d = BYTE_STAT;
			end else if (pos_q < POS_IDLE) begin
				pos_d = pos_q + 1'b1;
			end
			if (pos_d < POS_IDLE) begin
				case (pos_d)
					BYTE_STAT: rec_d.status_byte     = rx_byte;
					BYTE_LANE: rec_d.lane_bits       = grp;
					BYTE_X0:   rec_d.x_raw[23:21]    = rx_byte[2:0];
					BYTE_X1:   rec_d.x_raw[20:14]    = grp;
					BYTE_X2:   rec_d.x_raw[13:7]     = grp;
					BYTE_X3:   rec_d.x_raw[6:0]      = grp;
					BYTE_Y0:   rec_d.y_raw[13:7]     = grp;
					BYTE_Y1:   rec_d.y_raw[6:0]      = grp;
					BYTE_ANG0: rec_d.angle_raw[13:7] = grp;
					BYTE_ANG1: rec_d.angle_raw[6:0]  = grp;
					BYTE_TAG0: rec_d.tag_raw[27:21]  = grp;
					BYTE_TAG1: rec_d.tag_raw[20:14]  = grp;
					BYTE_TAG2: rec_d.tag_raw[13:7]   = grp;
					BYTE_TAG3: rec_d.tag_raw[6:0]    = grp;
					default: begin
					end
				endcase
			end
		end
	end

	// the last byte hands the completed frame to the queue
	assign rec_push = take && (pos_d == LAST_BYTE);
	assign rec_data = rec_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= POS_IDLE;
			rec_q <= '0;
		end else begin
			pos_q <= pos_d;
			rec_q <= rec_d;
		end
	end

endmodule

`default_nettype wire

@@ sv/psfp_queue.sv @@
`default_nettype none

module psfp_queue import psfp_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	input  wire frame_rec_t  push_data,
	output logic             full,
	input  wire logic        pop,
	output logic             empty,
	output frame_rec_t       pop_data
);

	frame_rec_t        mem [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push, do_pop;

	assign full     = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = mem[rd_ptr_q];

	// record storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

@@ sv/psfp_back.sv @@
`default_nettype none

module psfp_back import psfp_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  rec_avail,
	input  wire frame_rec_t            rec,
	output logic                       rec_pop,
	input  wire cal_t                  cal,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [OUT_DATA_W-1:0]      out_data
);

	logic                  head_id, no_pos, tag_seen, no_lane;
	logic [1:0]            lane_cnt;
	logic [25:0]           x_base, x_val;
	logic [15:0]           y_base, y_sgn, y_val;
	logic signed [16:0]    a_neg, a_wrap, a_off;
	logic [14:0]           a_val;
	logic                  out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	// flags
	assign head_id  = |rec.status_byte[5:4];
	assign no_pos   = rec.status_byte[1];
	assign tag_seen = rec.lane_bits[6];
	assign lane_cnt = rec.lane_bits[5:4];
	assign no_lane  = rec.lane_bits[2];

	// x: sign fix when a tag is seen, then offset
	always_comb begin
		x_base = (tag_seen && (rec.x_raw > X_SIGN_LIMIT)) ? {2'b11, rec.x_raw}
		                                                  : {2'b00, rec.x_raw};
		x_val  = x_base - {{9{cal.x_offset[16]}}, cal.x_offset};
	end

	// y: sign fix, mirror without position, then offset
	always_comb begin
		y_base = (rec.y_raw > Y_SIGN_LIMIT) ? {2'b11, rec.y_raw} : {2'b00, rec.y_raw};
		y_sgn  = no_pos ? (16'd0 - y_base) : y_base;
		y_val  = y_sgn - {{2{cal.y_offset[13]}}, cal.y_offset};
	end

	// angle: negate, wrap once, offset, saturate
	always_comb begin
		a_neg  = 17'sd0 - $signed({3'b000, rec.angle_raw});
		a_wrap = (a_neg < ANG_LOW) ? (a_neg + ANG_TURN) : a_neg;
		a_off  = a_wrap - $signed({{4{cal.angle_offset[12]}}, cal.angle_offset});
		if (a_off < ANG_SAT_MIN) begin
			a_val = ANG_SAT_MIN[14:0];
		end else if (a_off > ANG_SAT_MAX) begin
			a_val = ANG_SAT_MAX[14:0];
		end else begin
			a_val = a_off[14:0];
		end
	end

	// output register, refilled in the cycle its beat is taken when a record is waiting
	assign rec_pop = rec_avail && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rec_pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rec_pop) begin
			out_data_q <= {5'b00000, a_val, y_val, x_val, rec.tag_raw,
			               tag_seen, no_pos, no_lane, lane_cnt, head_id};
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

`default_nettype wire

@@ sv/psfp_checker.sv @@
`default_nettype none

module psfp_checker import psfp_pkg::*; (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  s_tvalid,
	input wire logic                  s_tready,
	input wire logic                  m_tvalid,
	input wire logic                  m_tready,
	input wire logic [OUT_DATA_W-1:0] m_tdata
);

	// a stalled record holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("record changed while stalled");

	// with the output register empty the byte side never stalls
	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("byte side stalled with no record pending");

	// a new record is preceded by the byte beat that completed its frame
	a_rec_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
		else $error("record without a preceding byte beat");

	// angle never exceeds the top of its wrapped range plus offset
	a_angle_max: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata[90:76]) <= 15'sd5895))
		else $error("angle out of range");

endmodule

bind position_sensor_frame_parser psfp_checker u_psfp_checker (.*);

`default_nettype wire

@@ sim/tb.sv @@
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import psfp_pkg::*;

	localparam int          WATCHDOG_LIMIT = 4000;
	localparam int          LONG_STALL     = 400;
	localparam int          SETTLE_CYCLES  = 4;
	localparam int          PHASE_BYTES    = 165;
	localparam int          PHASES         = 6;
	localparam logic [1:0]  CFG_UNUSED     = 2'd3;

	// decoded record, laid out exactly as m_tdata
	typedef struct packed {
		logic [4:0]  fill;
		logic [14:0] angle_tenths;
		logic [15:0] y_tenths;
		logic [25:0] x_tenths;
		logic [27:0] tag_number;
		logic        tag_seen;
		logic        no_position;
		logic        no_lane;
		logic [1:0]  lane_count;
		logic        head_id;
	} sensor_rec_t;

	// directed stimulus row: a byte sent reps times, optionally with a hand-written record
	typedef struct packed {
		logic [7:0]  rx_byte;
		logic        start;
		logic [4:0]  reps;
		logic        typed;
		sensor_rec_t rec;
	} dir_row_t;

	typedef enum {FLAV_RANDOM, FLAV_SMALL, FLAV_LARGE} frame_flavour_t;
	typedef enum {SEQ_FRAME, SEQ_BROKEN, SEQ_NOISE} seq_kind_t;

	// all-ones frame at zero offsets
	localparam sensor_rec_t FULL_REC = '{
		fill: 5'd0, angle_tenths: 15'h4E11, y_tenths: 16'd1, x_tenths: 26'h3FFFFFF,
		tag_number: 28'hFFFFFFF, tag_seen: 1'b1, no_position: 1'b1, no_lane: 1'b1,
		lane_count: 2'd3, head_id: 1'b1
	};

	localparam dir_row_t DIR_TAB [7] = '{
		'{8'h00, 1'b0, 5'd1,  1'b0, '0},        // stray bytes while idle
		'{8'hFF, 1'b0, 5'd1,  1'b0, '0},
		'{8'hA5, 1'b1, 5'd1,  1'b0, '0},        // frame opened
		'{8'h00, 1'b0, 5'd1,  1'b0, '0},
		'{8'hFF, 1'b1, 5'd1,  1'b0, '0},        // restart mid-frame
		'{8'hFF, 1'b0, 5'd19, 1'b0, '0},
		'{8'hFF, 1'b0, 5'd1,  1'b1, FULL_REC}   // last byte of the all-ones frame
	};

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [7:0]            s_tdata   = '0;
	logic                  s_tuser   = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [1:0]            cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	// frame decoder mirror
	logic [4:0]  fp_pos = POS_IDLE;
	logic [7:0]  fp_status = '0;
	logic [6:0]  fp_lane = '0;
	logic [23:0] fp_x = '0;
	logic [13:0] fp_y = '0;
	logic [13:0] fp_ang = '0;
	logic [27:0] fp_tag = '0;
	logic [16:0] x_off = '0;
	logic [13:0] y_off = '0;
	logic [12:0] ang_off = '0;

	sensor_rec_t records_due [$];
	int          fail_count = 0;
	int          bytes_used = 0;
	int          send_idle = 9;
	int          recv_idle = 59;
	int          quiet_cycles = 0;
	int          stall_left = 0;
	logic        stall_req = 1'b0;
	logic        stall_ack = 1'b0;

	position_sensor_frame_parser dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),   // rx_byte
		.s_tuser   (s_tuser),   // frame_start
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		// head_id, lane_count[2], no_lane, no_position, tag_seen, tag_number[28],
		// x_tenths[26], y_tenths[16], angle_tenths[15], zero fill[5]
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// advance the byte counter, capture fields and build the record on the last byte
	function automatic bit decode_byte(input logic [7:0] b, input logic st,
			output sensor_rec_t r);
		logic [6:0] g;
		int xv;
		int yv;
		int av;
		g = b[6:0];
		r = '0;
		if (st)
			fp_pos = '0;
		else if (fp_pos < FRAME_BYTES)
			fp_pos = fp_pos + 1'b1;
		if (fp_pos >= FRAME_BYTES)
			return 1'b0;
		case (fp_pos)
			BYTE_STAT: fp_status = b;
			BYTE_LANE: fp_lane = g;
			BYTE_X0:   fp_x[23:21] = b[2:0];
			BYTE_X1:   fp_x[20:14] = g;
			BYTE_X2:   fp_x[13:7] = g;
			BYTE_X3:   fp_x[6:0] = g;
			BYTE_Y0:   fp_y[13:7] = g;
			BYTE_Y1:   fp_y[6:0] = g;
			BYTE_ANG0: fp_ang[13:7] = g;
			BYTE_ANG1: fp_ang[6:0] = g;
			BYTE_TAG0: fp_tag[27:21] = g;
			BYTE_TAG1: fp_tag[20:14] = g;
			BYTE_TAG2: fp_tag[13:7] = g;
			BYTE_TAG3: fp_tag[6:0] = g;
			default: ;
		endcase
		if (fp_pos != LAST_BYTE)
			return 1'b0;

		// x is only signed when a tag is seen
		xv = int'(fp_x);
		if (fp_lane[6] && xv > 2000)
			xv = xv - (1 << 24);
		xv = xv - int'($signed(x_off));

		yv = int'(fp_y);
		if (yv > 2000)
			yv = yv - (1 << 14);
		if (fp_status[1])
			yv = -yv;
		yv = yv - int'($signed(y_off));

		// angle negated, wrapped once, offset, then clamped to 15 bits
		av = -int'(fp_ang);
		if (av < -1800)
			av = av + 3600;
		av = av - int'($signed(ang_off));
		if (av < -16384)
			av = -16384;
		if (av > 16383)
			av = 16383;

		r.head_id       = |fp_status[5:4];
		r.lane_count    = fp_lane[5:4];
		r.no_lane       = fp_lane[2];
		r.no_position   = fp_status[1];
		r.tag_seen      = fp_lane[6];
		r.tag_number    = fp_tag;
		r.x_tenths      = xv[25:0];
		r.y_tenths      = yv[15:0];
		r.angle_tenths  = av[14:0];
		return 1'b1;
	endfunction

	task automatic note_failure(input string msg);
		fail_count++;
		if (fail_count <= 10)
			$display("%s", msg);
	endtask

	// one byte beat on the slave side
	task automatic send_byte(input logic [7:0] b, input logic st, input logic typed = 1'b0,
			input sensor_rec_t typed_rec = '0);
		sensor_rec_t rec;
		while ($urandom_range(0, 99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tuser  <= st;
		do @(posedge clk); while (!s_tready);
		if (st || fp_pos != POS_IDLE)
			bytes_used++;
		if (decode_byte(b, st, rec))
			records_due.push_back(typed ? typed_rec : rec);
	endtask

	// one register beat; the caller lowers cfg_valid after the last one
	task automatic write_reg(input logic [1:0] idx, input logic [CFG_DATA_W-1:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_X_OFFSET:     x_off = d[16:0];
			CFG_Y_OFFSET:     y_off = d[13:0];
			CFG_ANGLE_OFFSET: ang_off = d[12:0];
			default: ;
		endcase
	endtask

	// drain all records and let the pipeline empty
	task automatic settle();
		s_tvalid <= 1'b0;
		while (records_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// offsets for one phase; the unused index and the upper data bits of the y and angle writes get junk
	task automatic configure(input int p);
		logic [16:0] xv;
		logic [13:0] yv;
		logic [12:0] av;
		logic [CFG_DATA_W-1:0] rnd;
		case (p)
			0: begin
				xv = 17'h10000;
				yv = 14'h2000;
				av = 13'h1000;
			end
			1: begin
				xv = 17'h0FFFF;
				yv = 14'h1FFF;
				av = 13'h0FFF;
			end
			PHASES - 1: begin
				xv = '0;
				yv = '0;
				av = '0;
			end
			default: begin
				xv = 17'($urandom);
				yv = 14'($urandom);
				av = 13'($urandom);
			end
		endcase
		write_reg(CFG_X_OFFSET, xv);
		rnd = CFG_DATA_W'($urandom);
		write_reg(CFG_UNUSED, rnd);
		rnd = CFG_DATA_W'($urandom);
		rnd[13:0] = yv;
		write_reg(CFG_Y_OFFSET, rnd);
		rnd = CFG_DATA_W'($urandom);
		rnd[12:0] = av;
		write_reg(CFG_ANGLE_OFFSET, rnd);
		cfg_valid <= 1'b0;
	endtask

	// random frame byte, biased towards the sign and wrap thresholds
	function automatic logic [7:0] frame_byte(input int k, input frame_flavour_t flav);
		logic [7:0] b;
		b = 8'($urandom);
		if (flav == FLAV_SMALL) begin
			if (k == BYTE_X0)
				b[2:0] = '0;
			if (k == BYTE_X1)
				b[6:0] = '0;
			if (k == BYTE_X2 || k == BYTE_Y0)
				b[6:4] = '0;
			if (k == BYTE_ANG0)
				b[6:0] = 7'($urandom_range(0, 14));
		end else if (flav == FLAV_LARGE) begin
			if (k == BYTE_ANG0)
				b[6:2] = 5'h1F;
			if (k == BYTE_X0)
				b[2:0] = 3'h7;
		end
		return b;
	endfunction

	// mostly whole frames, some cut short, some noise
	task automatic run_random(input int target);
		int pick;
		int len;
		seq_kind_t kind;
		frame_flavour_t flav;
		while (bytes_used < target) begin
			pick = $urandom_range(0, 9);
			kind = (pick < 8) ? SEQ_FRAME : (pick == 8) ? SEQ_BROKEN : SEQ_NOISE;
			pick = $urandom_range(0, 3);
			flav = (pick == 0) ? FLAV_SMALL : (pick == 1) ? FLAV_LARGE : FLAV_RANDOM;
			case (kind)
				SEQ_FRAME: begin
					for (int k = 0; k < FRAME_BYTES; k++)
						send_byte(frame_byte(k, flav), k == 0);
					if ($urandom_range(0, 3) == 0)
						send_byte(8'($urandom), 1'b0);
				end
				SEQ_BROKEN: begin
					len = $urandom_range(1, FRAME_BYTES - 2);
					for (int k = 0; k < len; k++)
						send_byte(frame_byte(k, flav), k == 0);
				end
				default: begin
					len = $urandom_range(1, 6);
					repeat (len) send_byte(8'($urandom), $urandom_range(0, 7) == 0);
				end
			endcase
		end
	endtask

	// receiver: random stalls, plus a long hold-off on request
	always @(posedge clk) begin
		if (stall_left != 0) begin
			m_tready   <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (stall_req != stall_ack) begin
			m_tready   <= 1'b0;
			stall_ack  <= stall_req;
			stall_left <= LONG_STALL;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= recv_idle);
		end
	end

	// record checker
	always @(posedge clk) begin
		sensor_rec_t got;
		sensor_rec_t want;
		string bad;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			if (records_due.size() == 0) begin
				note_failure($sformatf("unexpected record %h", got));
			end else begin
				want = records_due.pop_front();
				bad = "";
				if (got.head_id !== want.head_id) bad = {bad, " head_id"};
				if (got.lane_count !== want.lane_count) bad = {bad, " lane_count"};
				if (got.no_lane !== want.no_lane) bad = {bad, " no_lane"};
				if (got.no_position !== want.no_position) bad = {bad, " no_position"};
				if (got.tag_seen !== want.tag_seen) bad = {bad, " tag_seen"};
				if (got.tag_number !== want.tag_number) bad = {bad, " tag_number"};
				if (got.x_tenths !== want.x_tenths) bad = {bad, " x_tenths"};
				if (got.y_tenths !== want.y_tenths) bad = {bad, " y_tenths"};
				if (got.angle_tenths !== want.angle_tenths) bad = {bad, " angle_tenths"};
				if (got.fill !== want.fill) bad = {bad, " fill"};
				if (bad != "")
					note_failure($sformatf("record mismatch in%s: expected %h got %h",
						bad, want, got));
			end
		end
	end

	// watchdog on cycles with no beat anywhere
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// stimulus
	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table at reset offsets
		foreach (DIR_TAB[i])
			repeat (DIR_TAB[i].reps)
				send_byte(DIR_TAB[i].rx_byte, DIR_TAB[i].start, DIR_TAB[i].typed,
					DIR_TAB[i].rec);

		// random phases, each with its own offsets; each pair of phases shares an idle pattern
		for (int p = 0; p < PHASES; p++) begin
			settle();
			configure(p);
			case (p / 2)
				0: begin
					send_idle = 9;
					recv_idle = 59;
				end
				1: begin
					send_idle = 59;
					recv_idle = 9;
				end
				default: begin
					send_idle = 0;
					recv_idle = 0;
				end
			endcase
			if (p == 1 || p == 4)
				stall_req <= ~stall_req;
			run_random(bytes_used + PHASE_BYTES);
		end

		settle();
		repeat (8) @(posedge clk);
		if (fail_count == 0 && records_due.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
